[rtl/pfd_pkg.sv]
// shared types, constants and key square helpers for the playfair digraph encryptor
// no dependencies; used by every module under rtl
package pfd_pkg;

    localparam int SIDE       = 5;
    localparam int CELLS      = SIDE * SIDE;
    localparam int CODE_W     = 5;
    localparam int KEY_W      = CELLS * CODE_W;
    localparam int CHAR_W     = 8;
    localparam int POS_W      = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 50;
    localparam int ROW_PAIR_W = 50;
    localparam int ROW_LAST_W = 25;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CHAR_W-1:0] CH_PAD  = 8'h5A;   // 'Z'
    localparam logic [CHAR_W-1:0] CH_FILL = 8'h58;   // 'X'
    localparam logic [CHAR_W-1:0] CH_J    = 8'h4A;   // 'J'
    localparam logic [CHAR_W-1:0] CH_I    = 8'h49;   // 'I'
    localparam logic [CHAR_W-1:0] CH_A    = 8'h41;   // 'A'
    localparam logic [POS_W-1:0]  LAST_POS = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_MIDDLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_LAST    = 2'd2;

    localparam logic [ROW_PAIR_W-1:0] ROWS_FIRST_RST  = 50'd216709051748908;
    localparam logic [ROW_PAIR_W-1:0] ROWS_MIDDLE_RST = 50'd688860624693511;
    localparam logic [ROW_LAST_W-1:0] ROW_LAST_RST    = 25'd25942708;

    typedef struct packed {
        logic [CHAR_W-1:0] first_char;
        logic [POS_W-1:0]  r1;
        logic [POS_W-1:0]  c1;
        logic [POS_W-1:0]  r2;
        logic [POS_W-1:0]  c2;
        logic              last;
    } pair_job_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } loc_t;

    function automatic logic [CHAR_W-1:0] cell_char(input logic [KEY_W-1:0] key,
                                                    input logic [POS_W-1:0] row,
                                                    input logic [POS_W-1:0] col);
        logic [4:0] idx;
        logic [CODE_W-1:0] code;
        idx  = 5'(row) * 5'(SIDE) + 5'(col);
        code = key[idx * CODE_W +: CODE_W];
        return CH_A + CHAR_W'(code);
    endfunction

    // last match in cell order wins
    function automatic loc_t locate(input logic [KEY_W-1:0] key,
                                    input logic [CHAR_W-1:0] ch);
        loc_t res;
        res = '0;
        for (int r = 0; r < SIDE; r++) begin
            for (int c = 0; c < SIDE; c++) begin
                if (CH_A + CHAR_W'(key[(r * SIDE + c) * CODE_W +: CODE_W]) == ch) begin
                    res.found = 1'b1;
                    res.row   = POS_W'(r);
                    res.col   = POS_W'(c);
                end
            end
        end
        return res;
    endfunction

    function automatic logic [POS_W-1:0] next_pos(input logic [POS_W-1:0] v);
        return (v >= LAST_POS) ? '0 : v + 1'b1;
    endfunction

endpackage

[rtl/pfd_front.sv]
// front end: accepts plaintext characters, pairs them and locates them in the key square
// depends on pfd_pkg; pushes one pair job per digraph into pfd_queue
module pfd_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [pfd_pkg::KEY_W-1:0]      key,
    input  logic                           in_tvalid,
    output logic                           in_tready,
    input  logic [7:0]                     in_tdata,   // [7:0] plain_char
    input  logic                           in_tlast,   // end_of_text
    output logic                           push_valid,
    input  logic                           push_ready,
    output pfd_pkg::pair_job_t             push_job
);

    logic [pfd_pkg::CHAR_W-1:0] held_char_reg;
    logic                       holding_reg;
    logic [pfd_pkg::POS_W-1:0]  first_row_reg, first_col_reg;
    logic [pfd_pkg::POS_W-1:0]  second_row_reg, second_col_reg;

    logic [pfd_pkg::CHAR_W-1:0] ch_fix;
    pfd_pkg::loc_t              loc_in, loc_pad;
    logic [pfd_pkg::POS_W-1:0]  sel_row, sel_col, pad_row, pad_col;
    logic                       accept;

    always_comb
    begin
        ch_fix  = (in_tdata == pfd_pkg::CH_J) ? pfd_pkg::CH_I : in_tdata;
        loc_in  = pfd_pkg::locate(key, ch_fix);
        loc_pad = pfd_pkg::locate(key, pfd_pkg::CH_PAD);
        // a miss keeps the position found last for this slot
        if (holding_reg)
        begin
            sel_row = loc_in.found ? loc_in.row : second_row_reg;
            sel_col = loc_in.found ? loc_in.col : second_col_reg;
        end
        else
        begin
            sel_row = loc_in.found ? loc_in.row : first_row_reg;
            sel_col = loc_in.found ? loc_in.col : first_col_reg;
        end
        pad_row = loc_pad.found ? loc_pad.row : second_row_reg;
        pad_col = loc_pad.found ? loc_pad.col : second_col_reg;

        in_tready  = push_ready;
        push_valid = in_tvalid && (holding_reg || in_tlast);
        accept     = in_tvalid && in_tready;

        if (holding_reg)
        begin
            push_job.first_char = held_char_reg;
            push_job.r1         = first_row_reg;
            push_job.c1         = first_col_reg;
            push_job.r2         = sel_row;
            push_job.c2         = sel_col;
            push_job.last       = in_tlast;
        end
        else
        begin
            // odd-length message closes with the pad letter
            push_job.first_char = ch_fix;
            push_job.r1         = sel_row;
            push_job.c1         = sel_col;
            push_job.r2         = pad_row;
            push_job.c2         = pad_col;
            push_job.last       = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_char_reg  <= '0;
            holding_reg    <= 1'b0;
            first_row_reg  <= '0;
            first_col_reg  <= '0;
            second_row_reg <= '0;
            second_col_reg <= '0;
        end
        else if (accept)
        begin
            if (holding_reg)
            begin
                second_row_reg <= sel_row;
                second_col_reg <= sel_col;
                holding_reg    <= 1'b0;
                held_char_reg  <= '0;
            end
            else
            begin
                first_row_reg <= sel_row;
                first_col_reg <= sel_col;
                if (in_tlast)
                begin
                    second_row_reg <= pad_row;
                    second_col_reg <= pad_col;
                end
                else
                begin
                    held_char_reg <= ch_fix;
                    holding_reg   <= 1'b1;
                end
            end
        end
    end

    a_open_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !holding_reg && !in_tlast) |=> holding_reg)
        else $error("open pair not recorded");

    a_pair_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && holding_reg) |=> !holding_reg)
        else $error("pair not closed after second character");

endmodule

[rtl/pfd_queue.sv]
// short queue of pair jobs between the front end and the back end
// depends on pfd_pkg for the job type
module pfd_queue #(
    parameter int DEPTH = pfd_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  pfd_pkg::pair_job_t push_job,
    output logic               pop_valid,
    input  logic               pop_ready,
    output pfd_pkg::pair_job_t pop_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pfd_pkg::pair_job_t mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push, do_pop;

    always_comb
    begin
        push_ready = (count_reg != CNT_W'(DEPTH));
        pop_valid  = (count_reg != '0);
        pop_job    = mem[rd_ptr_reg];
        do_push    = push_valid && push_ready;
        do_pop     = pop_valid && pop_ready;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

endmodule

[rtl/pfd_back.sv]
// back end: turns one pair job into two cipher characters on the output stream
// depends on pfd_pkg; pulls jobs from pfd_queue
module pfd_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [pfd_pkg::KEY_W-1:0] key,
    input  logic                      pop_valid,
    output logic                      pop_ready,
    input  pfd_pkg::pair_job_t        pop_job,
    output logic                      out_tvalid,
    input  logic                      out_tready,
    output logic [7:0]                out_tdata,   // [7:0] cipher_char
    output logic                      out_tlast    // end_of_cipher
);

    pfd_pkg::pair_job_t         job_reg;
    logic                       busy_reg;
    logic                       phase_reg;   // 0: first letter, 1: second letter
    logic [pfd_pkg::CHAR_W-1:0] ch_a, ch_b;
    logic                       out_accept;

    always_comb
    begin
        priority if (job_reg.r1 == job_reg.r2 && job_reg.c1 == job_reg.c2)
        begin
            ch_a = job_reg.first_char;
            ch_b = pfd_pkg::CH_FILL;
        end
        else if (job_reg.r1 == job_reg.r2)
        begin
            ch_a = pfd_pkg::cell_char(key, job_reg.r1, pfd_pkg::next_pos(job_reg.c1));
            ch_b = pfd_pkg::cell_char(key, job_reg.r2, pfd_pkg::next_pos(job_reg.c2));
        end
        else if (job_reg.c1 == job_reg.c2)
        begin
            ch_a = pfd_pkg::cell_char(key, pfd_pkg::next_pos(job_reg.r1), job_reg.c1);
            ch_b = pfd_pkg::cell_char(key, pfd_pkg::next_pos(job_reg.r2), job_reg.c2);
        end
        else
        begin
            ch_a = pfd_pkg::cell_char(key, job_reg.r1, job_reg.c2);
            ch_b = pfd_pkg::cell_char(key, job_reg.r2, job_reg.c1);
        end

        out_tvalid = busy_reg;
        out_tdata  = phase_reg ? ch_b : ch_a;
        out_tlast  = busy_reg && phase_reg && job_reg.last;
        out_accept = out_tvalid && out_tready;
        // take the next job as the second letter leaves
        pop_ready  = !busy_reg || (out_accept && phase_reg);
    end

    always_ff @(posedge clk)
    begin
        if (pop_valid && pop_ready)
        begin
            job_reg <= pop_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            if (pop_ready)
            begin
                busy_reg  <= pop_valid;
                phase_reg <= 1'b0;
            end
            else if (out_accept)
            begin
                phase_reg <= 1'b1;
            end
        end
    end

    a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (out_accept && !phase_reg) |=> (out_tvalid && phase_reg))
        else $error("second letter of pair missing");

    a_last_on_second: assert property (@(posedge clk) disable iff (!rst_n)
        out_tlast |-> (phase_reg && busy_reg))
        else $error("end of cipher on first letter");

endmodule

[rtl/playfair_digraph_encrypt_top.sv]
// playfair digraph encryptor: one plaintext character per cycle unless stalled, two cipher characters per pair
// first result appears once the closing pair job has passed through the job queue into the back end job register
// throughput: one character in and one result out per cycle when neither side stalls; the back end sends two letters
// per pair against one pair job every two characters; a two-entry job queue decouples them
// reset (async, active low) clears the open pair, last positions and queue; key loads defaults
module playfair_digraph_encrypt_top #(
    parameter int QUEUE_DEPTH = pfd_pkg::QUEUE_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [pfd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pfd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // [7:0] plain_char
    input  logic                           s_axis_tlast,   // end_of_text
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [7:0]                     m_axis_tdata,   // [7:0] cipher_char
    output logic                           m_axis_tlast    // end_of_cipher
);

    logic [pfd_pkg::ROW_PAIR_W-1:0] rows_first_reg, rows_middle_reg;
    logic [pfd_pkg::ROW_LAST_W-1:0] row_last_reg;
    logic [pfd_pkg::KEY_W-1:0]      key;

    logic               push_valid, push_ready, pop_valid, pop_ready;
    pfd_pkg::pair_job_t push_job, pop_job;

    assign key = {row_last_reg, rows_middle_reg, rows_first_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_first_reg  <= pfd_pkg::ROWS_FIRST_RST;
            rows_middle_reg <= pfd_pkg::ROWS_MIDDLE_RST;
            row_last_reg    <= pfd_pkg::ROW_LAST_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pfd_pkg::REG_ROWS_FIRST:  rows_first_reg  <= cfg_data;
                pfd_pkg::REG_ROWS_MIDDLE: rows_middle_reg <= cfg_data;
                pfd_pkg::REG_ROW_LAST:    row_last_reg    <= cfg_data[pfd_pkg::ROW_LAST_W-1:0];
                default: ;
            endcase
        end
    end

    pfd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .key        (key),
        .in_tvalid  (s_axis_tvalid),
        .in_tready  (s_axis_tready),
        .in_tdata   (s_axis_tdata),
        .in_tlast   (s_axis_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    pfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    pfd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .key        (key),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job),
        .out_tvalid (m_axis_tvalid),
        .out_tready (m_axis_tready),
        .out_tdata  (m_axis_tdata),
        .out_tlast  (m_axis_tlast)
    );

endmodule
